@@ src/rpd_pkg.sv @@
`default_nettype none
package rpd_pkg;

  localparam int CAPACITY_DEF = 256;

  localparam int COORD_W   = 16;
  localparam int RADIUS_W  = 33;
  localparam int MAXPTS_W  = 9;
  localparam int SLOT_W    = 8;
  localparam int COUNT_W   = 9;
  localparam int ACTION_W  = 2;
  localparam int VERDICT_W = 2;
  localparam int REG_IDX_W = 1;

  localparam logic [RADIUS_W-1:0] RADIUS_SQ_RST = 33'd4096;
  localparam logic [MAXPTS_W-1:0] PT_LIMIT_RST  = 9'd256;

  localparam logic [REG_IDX_W-1:0] REG_RADIUS_SQ = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_PT_LIMIT  = 1'b1;

  localparam logic [ACTION_W-1:0] ACT_PRIMARY   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SECONDARY = 2'd1;

  localparam logic [VERDICT_W-1:0] V_STORED  = 2'd0;
  localparam logic [VERDICT_W-1:0] V_NEAR    = 2'd1;
  localparam logic [VERDICT_W-1:0] V_FULL    = 2'd2;
  localparam logic [VERDICT_W-1:0] V_CLEARED = 2'd3;

endpackage
`default_nettype wire

@@ src/rpd_ram.sv @@
`default_nettype none
module rpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/radius_point_dedup_list_core.sv @@
`default_nettype none
// Point list with radius deduplication. Pulse start with an action and a
// point; busy rises while a secondary point is compared against the list.
// Primary points, clears, points refused because the list is full and a
// secondary point on an empty list need no scan: the result shows on done
// in the cycle after start. Any other secondary point checks the stored
// points one per cycle through the single read port of the point memory,
// behind a read, abs diff, square, sum and compare pipeline, so busy stays
// high until the last one is compared, or falls early on a near point. The
// result comes with done, high for exactly one cycle; the receiver cannot
// stall it. A new item may start in the cycle after busy falls.
// Write radius_sq and the point limit only while idle.
module radius_point_dedup_list_core #(
  parameter int CAPACITY = rpd_pkg::CAPACITY_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [rpd_pkg::ACTION_W-1:0]   action,
  input  wire logic [rpd_pkg::COORD_W-1:0]    point_x,
  input  wire logic [rpd_pkg::COORD_W-1:0]    point_y,
  output logic                                done,
  output logic                                accepted,
  output logic      [rpd_pkg::SLOT_W-1:0]     slot,
  output logic      [rpd_pkg::VERDICT_W-1:0]  verdict,
  output logic      [rpd_pkg::COUNT_W-1:0]    list_count,
  input  wire logic                           wr_en,
  input  wire logic [rpd_pkg::REG_IDX_W-1:0]  wr_index,
  input  wire logic [rpd_pkg::RADIUS_W-1:0]   wr_data
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > rpd_pkg::MAXPTS_W) ? CNT_W : rpd_pkg::MAXPTS_W;
  localparam int CW     = rpd_pkg::COORD_W;
  localparam int SQ_W   = 2 * CW;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t state;

  logic [rpd_pkg::RADIUS_W-1:0] radius_sq;
  logic [rpd_pkg::MAXPTS_W-1:0] pt_limit;
  logic [CNT_W-1:0]             fill;
  logic [CNT_W-1:0]             iss;
  logic [CW-1:0]                pt_x;
  logic [CW-1:0]                pt_y;

  logic                         s1_v, s2_v, s3_v;
  logic [CW-1:0]                d_x, d_y;
  logic [SQ_W-1:0]              sq_x, sq_y;

  logic                         we;
  logic [ADDR_W-1:0]            waddr;
  logic [SQ_W-1:0]              wdata;
  logic [SQ_W-1:0]              rdata;

  logic                         take;
  logic                         full;
  logic                         issuing;
  logic [CW-1:0]                rd_x, rd_y;
  logic [CW-1:0]                dx_c, dy_c;
  logic [SQ_W-1:0]              sqx_c, sqy_c;
  logic [rpd_pkg::RADIUS_W-1:0] dist_sq;
  logic                         hit;
  logic                         drained;
  logic [CNT_W-1:0]             fill_inc;

  assign busy     = (state == S_SCAN);
  assign take     = start && !busy;
  assign full     = (CMP_W'(fill) >= CMP_W'(pt_limit)) || (fill >= CAP_CNT);
  assign issuing  = (state == S_SCAN) && (iss < fill);
  assign fill_inc = fill + CNT_W'(1);

  assign rd_x    = rdata[SQ_W-1:CW];
  assign rd_y    = rdata[CW-1:0];
  assign dx_c    = (pt_x >= rd_x) ? pt_x - rd_x : rd_x - pt_x;
  assign dy_c    = (pt_y >= rd_y) ? pt_y - rd_y : rd_y - pt_y;
  assign sqx_c   = d_x * d_x;
  assign sqy_c   = d_y * d_y;
  assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
  assign hit     = s3_v && (dist_sq < radius_sq);
  assign drained = !issuing && !s1_v && !s2_v && !s3_v;

  // Store either straight from the ports (primary point, or an empty list)
  // or from the latched point once a scan finds nothing near.
  always_comb begin
    we    = 1'b0;
    wdata = {point_x, point_y};
    if (state == S_IDLE) begin
      we = take && !action[1] && !full &&
           (action == rpd_pkg::ACT_PRIMARY || fill == '0);
    end else begin
      we    = !hit && drained;
      wdata = {pt_x, pt_y};
    end
  end
  assign waddr = fill[ADDR_W-1:0];

  rpd_ram #(
    .WIDTH (SQ_W),
    .DEPTH (CAPACITY)
  ) u_pts (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (iss[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_sq <= rpd_pkg::RADIUS_SQ_RST;
      pt_limit  <= rpd_pkg::PT_LIMIT_RST;
    end else if (wr_en) begin
      case (wr_index)
        rpd_pkg::REG_RADIUS_SQ: radius_sq <= wr_data;
        rpd_pkg::REG_PT_LIMIT:  pt_limit  <= wr_data[rpd_pkg::MAXPTS_W-1:0];
        default: ;
      endcase
    end
  end

  // Distance pipeline: read, abs diff, square, sum and compare.
  always_ff @(posedge clk) begin
    d_x  <= dx_c;
    d_y  <= dy_c;
    sq_x <= sqx_c;
    sq_y <= sqy_c;
    if (take) begin
      pt_x <= point_x;
      pt_y <= point_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      iss        <= '0;
      s1_v       <= 1'b0;
      s2_v       <= 1'b0;
      s3_v       <= 1'b0;
      done       <= 1'b0;
      accepted   <= 1'b0;
      slot       <= '0;
      verdict    <= rpd_pkg::V_STORED;
      list_count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          s1_v <= 1'b0;
          s2_v <= 1'b0;
          s3_v <= 1'b0;
          iss  <= '0;
          if (take) begin
            if (action[1]) begin
              fill       <= '0;
              done       <= 1'b1;
              accepted   <= 1'b0;
              slot       <= '0;
              verdict    <= rpd_pkg::V_CLEARED;
              list_count <= '0;
            end else if (full) begin
              done       <= 1'b1;
              accepted   <= 1'b0;
              slot       <= '0;
              verdict    <= rpd_pkg::V_FULL;
              list_count <= rpd_pkg::COUNT_W'(fill);
            end else if (action == rpd_pkg::ACT_PRIMARY || fill == '0) begin
              fill       <= fill_inc;
              done       <= 1'b1;
              accepted   <= 1'b1;
              slot       <= rpd_pkg::SLOT_W'(fill);
              verdict    <= rpd_pkg::V_STORED;
              list_count <= rpd_pkg::COUNT_W'(fill_inc);
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          s1_v <= issuing;
          s2_v <= s1_v;
          s3_v <= s2_v;
          if (issuing) begin
            iss <= iss + CNT_W'(1);
          end
          if (hit) begin
            // Drop on the first near point; in-flight beats are discarded.
            state      <= S_IDLE;
            done       <= 1'b1;
            accepted   <= 1'b0;
            slot       <= '0;
            verdict    <= rpd_pkg::V_NEAR;
            list_count <= rpd_pkg::COUNT_W'(fill);
          end else if (drained) begin
            state      <= S_IDLE;
            fill       <= fill_inc;
            done       <= 1'b1;
            accepted   <= 1'b1;
            slot       <= rpd_pkg::SLOT_W'(fill);
            verdict    <= rpd_pkg::V_STORED;
            list_count <= rpd_pkg::COUNT_W'(fill_inc);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CAP_CNT)
    else $error("fill count beyond capacity");

  a_store_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (accepted == (verdict == rpd_pkg::V_STORED)))
    else $error("accepted flag disagrees with verdict");

  a_store_count: assert property (@(posedge clk) disable iff (rst)
    (done && accepted) |-> (list_count == rpd_pkg::COUNT_W'(slot) + rpd_pkg::COUNT_W'(1)))
    else $error("stored slot does not match list count");

  a_scan_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done && (verdict == rpd_pkg::V_NEAR || verdict == rpd_pkg::V_STORED))
    else $error("scan ended without a result");

endmodule
`default_nettype wire

@@ tb/radius_point_dedup_list_core_tb.sv @@
`timescale 1ns / 100ps

module radius_point_dedup_list_core_tb;

  localparam int CAP          = rpd_pkg::CAPACITY_DEF;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 300;

  // Only bit 1 of the action is decoded for a clear.
  localparam logic [rpd_pkg::ACTION_W-1:0] ACT_CLEAR     = 2'd2;
  localparam logic [rpd_pkg::ACTION_W-1:0] ACT_CLEAR_ALT = 2'd3;

  typedef struct packed {
    logic                          accepted;
    logic [rpd_pkg::SLOT_W-1:0]    slot;
    logic [rpd_pkg::VERDICT_W-1:0] verdict;
    logic [rpd_pkg::COUNT_W-1:0]   fill;
  } outcome_t;

  typedef struct {
    bit                            is_cfg;
    logic [rpd_pkg::REG_IDX_W-1:0] cfg_index;
    logic [rpd_pkg::RADIUS_W-1:0]  cfg_data;
    logic [rpd_pkg::ACTION_W-1:0]  act;
    logic [rpd_pkg::COORD_W-1:0]   x;
    logic [rpd_pkg::COORD_W-1:0]   y;
    bit                            fixed;
    outcome_t                      want;
  } step_t;

  logic                           clk;
  logic                           rst      = 1'b1;
  logic                           start    = 1'b0;
  logic [rpd_pkg::ACTION_W-1:0]   action   = '0;
  logic [rpd_pkg::COORD_W-1:0]    point_x  = '0;
  logic [rpd_pkg::COORD_W-1:0]    point_y  = '0;
  logic                           wr_en    = 1'b0;
  logic [rpd_pkg::REG_IDX_W-1:0]  wr_index = '0;
  logic [rpd_pkg::RADIUS_W-1:0]   wr_data  = '0;
  logic                           busy;
  logic                           done;
  logic                           accepted;
  logic [rpd_pkg::SLOT_W-1:0]     slot;
  logic [rpd_pkg::VERDICT_W-1:0]  verdict;
  logic [rpd_pkg::COUNT_W-1:0]    list_count;

  radius_point_dedup_list_core dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .point_x    (point_x),
    .point_y    (point_y),
    .done       (done),
    .accepted   (accepted),
    .slot       (slot),
    .verdict    (verdict),
    .list_count (list_count),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data)
  );

  // Local copy of the point list and its settings.
  logic [rpd_pkg::RADIUS_W-1:0] radius_sq_cfg = rpd_pkg::RADIUS_SQ_RST;
  logic [rpd_pkg::MAXPTS_W-1:0] limit_cfg     = rpd_pkg::PT_LIMIT_RST;
  logic [rpd_pkg::COORD_W-1:0]  list_x [CAP];
  logic [rpd_pkg::COORD_W-1:0]  list_y [CAP];
  int                           list_fill = 0;

  outcome_t due_outcomes[$];
  step_t    plan[$];
  int       mismatch_count = 0;
  int       idle_cycles    = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic outcome_t judge_point(input logic [rpd_pkg::ACTION_W-1:0] act,
                                           input logic [rpd_pkg::COORD_W-1:0] x,
                                           input logic [rpd_pkg::COORD_W-1:0] y);
    outcome_t        o;
    int              lim;
    bit              near;
    longint unsigned dx;
    longint unsigned dy;
    o    = '0;
    near = 1'b0;
    lim  = (int'(limit_cfg) < CAP) ? int'(limit_cfg) : CAP;
    if (act[1]) begin
      list_fill = 0;
      o.verdict = rpd_pkg::V_CLEARED;
    end else if (list_fill >= lim) begin
      o.verdict = rpd_pkg::V_FULL;
    end else begin
      if (act == rpd_pkg::ACT_SECONDARY) begin
        for (int i = 0; i < list_fill; i++) begin
          dx = (x >= list_x[i]) ? longint'(x - list_x[i]) : longint'(list_x[i] - x);
          dy = (y >= list_y[i]) ? longint'(y - list_y[i]) : longint'(list_y[i] - y);
          if (dx * dx + dy * dy < longint'(radius_sq_cfg)) near = 1'b1;
        end
      end
      if (near) begin
        o.verdict = rpd_pkg::V_NEAR;
      end else begin
        o.accepted        = 1'b1;
        o.slot            = rpd_pkg::SLOT_W'(list_fill);
        o.verdict         = rpd_pkg::V_STORED;
        list_x[list_fill] = x;
        list_y[list_fill] = y;
        list_fill++;
      end
    end
    o.fill = rpd_pkg::COUNT_W'(list_fill);
    return o;
  endfunction

  function automatic step_t cfg_row(input logic [rpd_pkg::REG_IDX_W-1:0] idx,
                                    input logic [rpd_pkg::RADIUS_W-1:0] data);
    step_t s;
    s           = '{default: '0};
    s.is_cfg    = 1'b1;
    s.cfg_index = idx;
    s.cfg_data  = data;
    return s;
  endfunction

  function automatic step_t open_row(input logic [rpd_pkg::ACTION_W-1:0] act,
                                     input logic [rpd_pkg::COORD_W-1:0] x,
                                     input logic [rpd_pkg::COORD_W-1:0] y);
    step_t s;
    s     = '{default: '0};
    s.act = act;
    s.x   = x;
    s.y   = y;
    return s;
  endfunction

  function automatic step_t fixed_row(input logic [rpd_pkg::ACTION_W-1:0] act,
                                      input logic [rpd_pkg::COORD_W-1:0] x,
                                      input logic [rpd_pkg::COORD_W-1:0] y,
                                      input logic acc, input int slot_no,
                                      input logic [rpd_pkg::VERDICT_W-1:0] v,
                                      input int fill);
    step_t s;
    s       = open_row(act, x, y);
    s.fixed = 1'b1;
    s.want  = '{acc, rpd_pkg::SLOT_W'(slot_no), v, rpd_pkg::COUNT_W'(fill)};
    return s;
  endfunction

  // Hold start until the beat is taken, then log what the list should report.
  task automatic send_point(input logic [rpd_pkg::ACTION_W-1:0] act,
                            input logic [rpd_pkg::COORD_W-1:0] x,
                            input logic [rpd_pkg::COORD_W-1:0] y, input bit fixed,
                            input outcome_t want);
    outcome_t calc;
    @(negedge clk);
    start   <= 1'b1;
    action  <= act;
    point_x <= x;
    point_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    calc = judge_point(act, x, y);
    due_outcomes = {due_outcomes, (fixed ? want : calc)};
  endtask

  task automatic pause_sender(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Write only once the block has drained every outstanding beat.
  task automatic write_reg(input logic [rpd_pkg::REG_IDX_W-1:0] idx,
                           input logic [rpd_pkg::RADIUS_W-1:0] data);
    @(negedge clk);
    start <= 1'b0;
    while (due_outcomes.size() != 0 || busy) @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(negedge clk);
    wr_en <= 1'b0;
    if (idx == rpd_pkg::REG_RADIUS_SQ) radius_sq_cfg = data;
    else if (idx == rpd_pkg::REG_PT_LIMIT) limit_cfg = data[rpd_pkg::MAXPTS_W-1:0];
  endtask

  task automatic pick_point(input int clear_pct, input int prim_pct,
                            output logic [rpd_pkg::ACTION_W-1:0] act,
                            output logic [rpd_pkg::COORD_W-1:0] x,
                            output logic [rpd_pkg::COORD_W-1:0] y);
    int r;
    int k;
    int spread;
    r = $urandom_range(0, 99);
    if (r < clear_pct) act = $urandom_range(0, 1) ? ACT_CLEAR : ACT_CLEAR_ALT;
    else if (r < clear_pct + prim_pct) act = rpd_pkg::ACT_PRIMARY;
    else act = rpd_pkg::ACT_SECONDARY;
    if (list_fill != 0 && $urandom_range(0, 99) < 60) begin
      // Land near a stored point so the radius test sees hits and close misses.
      k      = $urandom_range(0, list_fill - 1);
      r      = $urandom_range(0, 2);
      spread = (r == 0) ? 2 : ((r == 1) ? 48 : 700);
      x = list_x[k] + rpd_pkg::COORD_W'(spread)
          - rpd_pkg::COORD_W'($urandom_range(0, 2 * spread));
      y = list_y[k] + rpd_pkg::COORD_W'(spread)
          - rpd_pkg::COORD_W'($urandom_range(0, 2 * spread));
    end else begin
      x = rpd_pkg::COORD_W'($urandom_range(0, 65535));
      y = rpd_pkg::COORD_W'($urandom_range(0, 65535));
    end
  endtask

  always @(posedge clk) begin : check_outcomes
    outcome_t seen;
    outcome_t due;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done) begin
        seen = {accepted, slot, verdict, list_count};
        if (due_outcomes.size() == 0) begin
          $display("%0t: unexpected beat: accepted %0d slot %0d verdict %0d count %0d",
                   $time, seen.accepted, seen.slot, seen.verdict, seen.fill);
          mismatch_count++;
        end else begin
          due = due_outcomes.pop_front();
          if (seen !== due) begin
            $display("%0t: exp/act acc %0d/%0d slot %0d/%0d verdict %0d/%0d count %0d/%0d",
                     $time, due.accepted, seen.accepted, due.slot, seen.slot,
                     due.verdict, seen.verdict, due.fill, seen.fill);
            mismatch_count++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("radius_point_dedup_list_core_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    logic [rpd_pkg::ACTION_W-1:0] act;
    logic [rpd_pkg::COORD_W-1:0]  x;
    logic [rpd_pkg::COORD_W-1:0]  y;
    logic [rpd_pkg::RADIUS_W-1:0] rad;
    int                           lim;
    int                           n;
    int                           clear_pct;
    int                           prim_pct;
    bit                           quiet;

    // Reset defaults first, then the radius boundary, both clear codes, empty and
    // lowered limits, and the radius extremes.
    plan = {plan, fixed_row(rpd_pkg::ACT_PRIMARY, 16'h0000, 16'h0000, 1'b1, 0,
                            rpd_pkg::V_STORED, 1)};
    plan = {plan, fixed_row(rpd_pkg::ACT_SECONDARY, 16'h0000, 16'h0000, 1'b0, 0,
                            rpd_pkg::V_NEAR, 1)};
    plan = {plan, open_row(rpd_pkg::ACT_SECONDARY, 16'd63, 16'h0000)};
    plan = {plan, open_row(rpd_pkg::ACT_SECONDARY, 16'd64, 16'h0000)};
    plan = {plan, fixed_row(rpd_pkg::ACT_PRIMARY, 16'h0000, 16'h0000, 1'b1, 2,
                            rpd_pkg::V_STORED, 3)};
    plan = {plan, open_row(rpd_pkg::ACT_SECONDARY, 16'hFFFF, 16'hFFFF)};
    plan = {plan, open_row(rpd_pkg::ACT_PRIMARY, 16'hFFFF, 16'h0000)};
    plan = {plan, open_row(rpd_pkg::ACT_SECONDARY, 16'hFFFF, 16'hFFC0)};
    plan = {plan, fixed_row(ACT_CLEAR_ALT, 16'hABCD, 16'h1234, 1'b0, 0,
                            rpd_pkg::V_CLEARED, 0)};
    plan = {plan, fixed_row(rpd_pkg::ACT_SECONDARY, 16'h1234, 16'h5678, 1'b1, 0,
                            rpd_pkg::V_STORED, 1)};
    plan = {plan, fixed_row(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 1'b0, 0,
                            rpd_pkg::V_CLEARED, 0)};
    plan = {plan, fixed_row(ACT_CLEAR, 16'h0000, 16'h0000, 1'b0, 0,
                            rpd_pkg::V_CLEARED, 0)};
    plan = {plan, cfg_row(rpd_pkg::REG_PT_LIMIT, 33'h1_FFFF_FE00)};
    plan = {plan, fixed_row(rpd_pkg::ACT_PRIMARY, 16'd5, 16'd5, 1'b0, 0,
                            rpd_pkg::V_FULL, 0)};
    plan = {plan, fixed_row(rpd_pkg::ACT_SECONDARY, 16'd5, 16'd5, 1'b0, 0,
                            rpd_pkg::V_FULL, 0)};
    plan = {plan, cfg_row(rpd_pkg::REG_PT_LIMIT, 33'd2)};
    plan = {plan, fixed_row(rpd_pkg::ACT_PRIMARY, 16'd100, 16'd100, 1'b1, 0,
                            rpd_pkg::V_STORED, 1)};
    plan = {plan, fixed_row(rpd_pkg::ACT_PRIMARY, 16'd100, 16'd100, 1'b1, 1,
                            rpd_pkg::V_STORED, 2)};
    plan = {plan, fixed_row(rpd_pkg::ACT_SECONDARY, 16'd100, 16'd100, 1'b0, 0,
                            rpd_pkg::V_FULL, 2)};
    plan = {plan, cfg_row(rpd_pkg::REG_PT_LIMIT, 33'd1)};
    plan = {plan, fixed_row(rpd_pkg::ACT_PRIMARY, 16'd7, 16'd7, 1'b0, 0,
                            rpd_pkg::V_FULL, 2)};
    plan = {plan, cfg_row(rpd_pkg::REG_RADIUS_SQ, 33'd0)};
    plan = {plan, cfg_row(rpd_pkg::REG_PT_LIMIT, 33'd256)};
    plan = {plan, fixed_row(rpd_pkg::ACT_SECONDARY, 16'd100, 16'd100, 1'b1, 2,
                            rpd_pkg::V_STORED, 3)};
    plan = {plan, cfg_row(rpd_pkg::REG_RADIUS_SQ, 33'h1_FFFF_FFFF)};
    plan = {plan, fixed_row(rpd_pkg::ACT_SECONDARY, 16'hFFFF, 16'hFFFF, 1'b0, 0,
                            rpd_pkg::V_NEAR, 3)};
    plan = {plan, fixed_row(ACT_CLEAR, 16'h8000, 16'h0001, 1'b0, 0,
                            rpd_pkg::V_CLEARED, 0)};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].cfg_index, plan[i].cfg_data);
      else send_point(plan[i].act, plan[i].x, plan[i].y, plan[i].fixed, plan[i].want);
    end

    for (int p = 0; p < 5; p++) begin
      clear_pct = 3;
      prim_pct  = 40;
      quiet     = 1'b0;
      case (p)
        0: begin
          rad = rpd_pkg::RADIUS_SQ_RST;
          lim = 256;
          n   = 60;
        end
        1: begin
          rad   = rpd_pkg::RADIUS_W'($urandom_range(0, 65535));
          lim   = $urandom_range(4, 40);
          n     = 60;
          quiet = 1'b1;
        end
        2: begin
          // Fill to capacity: no clears, mostly primaries.
          rad       = 33'd256;
          lim       = 256;
          n         = 280;
          clear_pct = 0;
          prim_pct  = 75;
        end
        3: begin
          rad       = {1'($urandom_range(0, 1)), 32'($urandom())};
          lim       = $urandom_range(0, 256);
          n         = 30;
          clear_pct = 5;
        end
        default: begin
          rad       = 33'h1_FFFF_FFFF;
          lim       = 511;
          n         = 20;
          clear_pct = 10;
        end
      endcase
      write_reg(rpd_pkg::REG_RADIUS_SQ, rad);
      write_reg(rpd_pkg::REG_PT_LIMIT,
                {1'($urandom_range(0, 1)), 23'($urandom()), rpd_pkg::MAXPTS_W'(lim)});
      for (int i = 0; i < n; i++) begin
        if (!quiet && $urandom_range(0, 99) < 24) pause_sender($urandom_range(1, 5));
        pick_point(clear_pct, prim_pct, act, x, y);
        send_point(act, x, y, 1'b0, '0);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (due_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("radius_point_dedup_list_core_tb: clean");
    end else begin
      $display("radius_point_dedup_list_core_tb: errors");
    end
    $finish;
  end

endmodule
